>>> rtl/core/cld_pkg.sv
// Shared constants for the stranded distance clusterer.
package cld_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF    = 16;
  localparam int CHROM_ID_BITS_DEF = 8;

  // Fixed field widths
  localparam int CHROM_BITS     = 8;
  localparam int COORD_BITS     = 32;
  localparam int SCORE_BITS     = 20;
  localparam int JOIN_BITS      = 20;
  localparam int MINC_BITS      = 16;
  localparam int OUT_COUNT_BITS = 16;
  localparam int MEAN_BITS      = 10;

  // Mean score arithmetic: sum / (count * 1000), capped at 1000
  localparam int SCORE_SCALE = 1000;
  localparam int SCALE_BITS  = 10;
  localparam int QUOT_BITS   = 11;
  localparam int MEAN_MAX    = 1000;

  // Stream packing
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int JOIN_RESET  = 100;
  localparam int MINC_RESET  = 1;
  localparam logic REG_JOIN_SIZE   = 1'b0;
  localparam logic REG_MIN_CLUSTER = 1'b1;

  // Request kinds and strands
  localparam logic ACT_SITE     = 1'b0;
  localparam logic ACT_FLUSH    = 1'b1;
  localparam logic STRAND_PLUS  = 1'b0;
  localparam logic STRAND_MINUS = 1'b1;

endpackage

>>> rtl/core/cld_div.sv
// Shared restoring divider: score sum over count times 1000, one quotient bit a cycle.
module cld_div #(
  parameter int COUNT_BITS = cld_pkg::COUNT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [COUNT_BITS+cld_pkg::SCORE_BITS-1:0]  sum_i,
  input  logic [COUNT_BITS-1:0]                      cnt_i,
  output logic                                       busy,
  output logic [cld_pkg::QUOT_BITS-1:0]              quot
);
  import cld_pkg::*;

  localparam int SUMW  = COUNT_BITS + SCORE_BITS;
  localparam int PRODW = COUNT_BITS + SCALE_BITS;
  localparam int SHIFT = QUOT_BITS - 1;
  localparam int DENW  = PRODW + SHIFT;
  localparam int WIDE  = (SUMW > DENW) ? SUMW : DENW;
  localparam int STEPW = $clog2(QUOT_BITS + 1);

  logic             busy_r;
  logic [STEPW-1:0] step_r;
  logic [WIDE-1:0]  rem_r;
  logic [WIDE-1:0]  den_r;
  logic [QUOT_BITS-1:0] quot_r;
  logic [PRODW-1:0] prod;
  logic             ge;

  // Divisor is count times the score scale
  assign prod = PRODW'(cnt_i) * PRODW'(SCORE_SCALE);
  assign ge   = (rem_r >= den_r);

  // Load operands, then trial-subtract from the top quotient bit down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEPW'(QUOT_BITS);
      rem_r  <= WIDE'(sum_i);
      den_r  <= WIDE'({prod, {SHIFT{1'b0}}});
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      quot_r <= {quot_r[QUOT_BITS-2:0], ge};
      den_r  <= den_r >> 1;
      step_r <= step_r - STEPW'(1);
      if (step_r == STEPW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

>>> rtl/core/stranded_distance_clusterer_unit.sv
// Top level: per-strand cluster tracking, sequencer, output register and config port.
//
// Input stream (in_*): one request per site record or flush. A record joins the
// open cluster of its strand or closes it (chromosome change, or start step above
// join_size) and starts a new one. A flush closes the plus cluster, then the
// minus cluster, and clears both strands.
// Output stream (out_*): one request per closed cluster with at least
// min_cluster members; out_tlast marks the final result of an input request.
// Configuration (cfg_*): APB-style, join_size at 0x0, min_cluster at 0x4. The user
// must write them only while the block is idle; the block does not enforce it.
// pready is always high. After a record that closes no reported cluster is
// accepted, in_tready stays low through the decide and apply states. Each reported
// cluster also passes through the divide and push states; the shared divider computes
// the mean score one quotient bit a cycle.
// Reset: both strands empty, join_size 100, min_cluster 1, no result pending.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds before loading the next result.
module stranded_distance_clusterer_unit #(
  parameter int COUNT_BITS    = cld_pkg::COUNT_BITS_DEF,
  parameter int CHROM_ID_BITS = cld_pkg::CHROM_ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: chrom_id[7:0], site_start[39:8], site_end[71:40], site_score[91:72], zero pad
  input  logic [cld_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: action[0], on_minus[1]
  input  logic [cld_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Output stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: out_chrom[7:0], cluster_start[39:8], cluster_end[71:40],
  //        member_count[87:72], mean_score[97:88], zero pad
  output logic [cld_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: out_minus[0]
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast,
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cld_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cld_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cld_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import cld_pkg::*;

  localparam int SUMW   = COUNT_BITS + SCORE_BITS;
  localparam int CMPW   = (COUNT_BITS > MINC_BITS) ? COUNT_BITS : MINC_BITS;
  localparam int OUT_PAD = OUT_TDATA_W - (CHROM_BITS + 2 * COORD_BITS + OUT_COUNT_BITS
                                          + MEAN_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_PUSH,
    ST_APPLY
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [JOIN_BITS-1:0] join_size_r;
  logic [MINC_BITS-1:0] min_cluster_r;

  // Latched request
  logic                     item_flush_r;
  logic [CHROM_ID_BITS-1:0] item_chrom_r;
  logic [COORD_BITS-1:0]    item_start_r;
  logic [COORD_BITS-1:0]    item_end_r;
  logic [SCORE_BITS-1:0]    item_score_r;
  logic                     cur_r;
  logic                     close_r;

  // Per-strand cluster state
  logic                     has_prev_r    [2];
  logic [CHROM_ID_BITS-1:0] chrom_r       [2];
  logic [COORD_BITS-1:0]    prev_start_r  [2];
  logic [COORD_BITS-1:0]    first_start_r [2];
  logic [COORD_BITS-1:0]    last_end_r    [2];
  logic [COUNT_BITS-1:0]    cnt_r         [2];
  logic [SUMW-1:0]          sum_r         [2];

  // Output register
  logic                      out_tvalid_r;
  logic                      out_minus_r;
  logic                      out_last_r;
  logic [CHROM_BITS-1:0]     out_chrom_r;
  logic [COORD_BITS-1:0]     out_start_r;
  logic [COORD_BITS-1:0]     out_end_r;
  logic [OUT_COUNT_BITS-1:0] out_count_r;
  logic [MEAN_BITS-1:0]      out_mean_r;

  // Control
  logic                  in_fire;
  logic                  cfg_wr;
  logic                  out_free;
  logic                  qual_cur;
  logic                  qual_minus;
  logic                  close_now;
  logic [COORD_BITS-1:0] start_step;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [SUMW-1:0]       base_sum;
  logic                  div_start;
  logic                  div_busy;
  logic [QUOT_BITS-1:0]  div_quot;
  logic [MEAN_BITS-1:0]  mean_sat;
  logic                  out_load;
  logic                  strand_adv;
  logic                  flush_clear;
  logic                  apply_en;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_free  = !out_tvalid_r || out_tready;

  // Cluster qualification and join test
  assign qual_cur   = has_prev_r[cur_r] && (cnt_r[cur_r] != '0) &&
                      (CMPW'(cnt_r[cur_r]) >= CMPW'(min_cluster_r));
  assign qual_minus = has_prev_r[STRAND_MINUS] && (cnt_r[STRAND_MINUS] != '0) &&
                      (CMPW'(cnt_r[STRAND_MINUS]) >= CMPW'(min_cluster_r));
  assign start_step = item_start_r - prev_start_r[cur_r];
  assign close_now  = has_prev_r[cur_r] &&
                      ((item_chrom_r != chrom_r[cur_r]) ||
                       (start_step > COORD_BITS'(join_size_r)));
  assign base_cnt   = close_r ? '0 : cnt_r[cur_r];
  assign base_sum   = close_r ? '0 : sum_r[cur_r];
  assign mean_sat   = (div_quot > QUOT_BITS'(MEAN_MAX)) ? MEAN_BITS'(MEAN_MAX)
                                                        : div_quot[MEAN_BITS-1:0];

  cld_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum_i (sum_r[cur_r]),
    .cnt_i (cnt_r[cur_r]),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // Sequence a request: decide, divide, push the result, update the strand
  always_comb begin
    state_nxt   = state_r;
    div_start   = 1'b0;
    out_load    = 1'b0;
    strand_adv  = 1'b0;
    flush_clear = 1'b0;
    apply_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (item_flush_r == ACT_FLUSH) begin
          if (qual_cur) begin
            div_start = 1'b1;
            state_nxt = ST_DIVIDE;
          end else if (cur_r == STRAND_PLUS) begin
            strand_adv = 1'b1;
          end else begin
            flush_clear = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (close_now && qual_cur) begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end else begin
          state_nxt = ST_APPLY;
        end
      end
      ST_DIVIDE: begin
        if (!div_busy) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (item_flush_r == ACT_SITE) begin
            state_nxt = ST_APPLY;
          end else if (cur_r == STRAND_PLUS) begin
            strand_adv = 1'b1;
            state_nxt  = ST_DECIDE;
          end else begin
            flush_clear = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_APPLY: begin
        apply_en  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, strand registers, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_r         <= STRAND_PLUS;
      out_tvalid_r  <= 1'b0;
      join_size_r   <= JOIN_BITS'(JOIN_RESET);
      min_cluster_r <= MINC_BITS'(MINC_RESET);
      has_prev_r    <= '{default: 1'b0};
      cnt_r         <= '{default: '0};
      sum_r         <= '{default: '0};
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_JOIN_SIZE:   join_size_r   <= cfg_pwdata[JOIN_BITS-1:0];
          REG_MIN_CLUSTER: min_cluster_r <= cfg_pwdata[MINC_BITS-1:0];
          default: ;
        endcase
      end

      // Capture the request
      if (in_fire) begin
        item_flush_r <= in_tuser[0];
        item_chrom_r <= CHROM_ID_BITS'(in_tdata[7:0]);
        item_start_r <= in_tdata[39:8];
        item_end_r   <= in_tdata[71:40];
        item_score_r <= in_tdata[91:72];
        cur_r        <= (in_tuser[0] == ACT_FLUSH) ? STRAND_PLUS : in_tuser[1];
      end

      if (state_r == ST_DECIDE) begin
        close_r <= close_now;
      end

      // Hold a result until taken, then drop it
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_minus_r  <= cur_r;
        out_last_r   <= (item_flush_r == ACT_SITE) || (cur_r == STRAND_MINUS) ||
                        !qual_minus;
        out_chrom_r  <= CHROM_BITS'(chrom_r[cur_r]);
        out_start_r  <= first_start_r[cur_r];
        out_end_r    <= last_end_r[cur_r];
        out_count_r  <= OUT_COUNT_BITS'(cnt_r[cur_r]);
        out_mean_r   <= mean_sat;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (strand_adv) begin
        cur_r <= STRAND_MINUS;
      end

      // Flush done: empty both strands
      if (flush_clear) begin
        has_prev_r <= '{default: 1'b0};
        cnt_r      <= '{default: '0};
        sum_r      <= '{default: '0};
      end

      // Add the site to its strand's cluster
      if (apply_en) begin
        if (base_cnt == '0) begin
          first_start_r[cur_r] <= item_start_r;
        end
        if (base_cnt != COUNT_MAX) begin
          cnt_r[cur_r] <= base_cnt + COUNT_BITS'(1);
          sum_r[cur_r] <= base_sum + SUMW'(item_score_r);
        end else begin
          cnt_r[cur_r] <= base_cnt;
          sum_r[cur_r] <= base_sum;
        end
        last_end_r[cur_r]   <= item_end_r;
        prev_start_r[cur_r] <= item_start_r;
        chrom_r[cur_r]      <= item_chrom_r;
        has_prev_r[cur_r]   <= 1'b1;
      end
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_paddr[2])
      REG_JOIN_SIZE:   cfg_prdata = CFG_DATA_W'(join_size_r);
      REG_MIN_CLUSTER: cfg_prdata = CFG_DATA_W'(min_cluster_r);
      default:         cfg_prdata = '0;
    endcase
  end
  assign cfg_pready = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_mean_r, out_count_r, out_end_r, out_start_r,
                       out_chrom_r};
  assign out_tuser  = out_minus_r;
  assign out_tlast  = out_last_r;

  // The divider only runs while a request is in progress
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  // Mean score is capped
  a_mean_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_mean_r <= MEAN_BITS'(MEAN_MAX)))
    else $error("mean score above cap");

  // An open cluster always holds at least one member
  a_plus_open: assert property (@(posedge clk) disable iff (!rst_n)
    has_prev_r[STRAND_PLUS] |-> (cnt_r[STRAND_PLUS] != '0))
    else $error("plus cluster open with zero count");

  a_minus_open: assert property (@(posedge clk) disable iff (!rst_n)
    has_prev_r[STRAND_MINUS] |-> (cnt_r[STRAND_MINUS] != '0))
    else $error("minus cluster open with zero count");

endmodule

>>> tb/sv/tb_stranded_distance_clusterer_unit.sv
// Self-checking testbench for the stranded distance clusterer: directed and random requests.
module tb_stranded_distance_clusterer_unit;
  import cld_pkg::*;

  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 40;    // covers a flush reporting both strands
  localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;

  typedef struct {
    bit        action;
    bit [7:0]  chrom;
    bit [31:0] site_start;
    bit [31:0] site_end;
    bit [19:0] score;
    bit        minus;
  } site_req_t;

  typedef struct {
    bit        minus;
    bit [7:0]  chrom;
    bit [31:0] first_start;
    bit [31:0] last_end;
    bit [15:0] members;
    bit [9:0]  mean;
    bit        last;
  } cluster_t;

  // Tracks both open clusters and queues the cluster reports they must produce
  class cluster_scoreboard;
    bit [19:0] join_size;
    bit [15:0] min_members;
    bit        has_prev[2];
    bit [7:0]  prev_chrom[2];
    bit [31:0] prev_start[2];
    bit [31:0] first_start[2];
    bit [31:0] last_end[2];
    bit [15:0] members[2];
    bit [35:0] score_sum[2];
    cluster_t  expected_q[$];
    cluster_t  batch[$];
    int        errors;

    function new();
      join_size   = JOIN_RESET;
      min_members = MINC_RESET;
      errors      = 0;
      clear_strand(0);
      clear_strand(1);
    endfunction

    function void clear_strand(int s);
      has_prev[s]    = 1'b0;
      prev_chrom[s]  = '0;
      prev_start[s]  = '0;
      first_start[s] = '0;
      last_end[s]    = '0;
      members[s]     = '0;
      score_sum[s]   = '0;
    endfunction

    function void set_config(bit idx, bit [31:0] value);
      if (idx == REG_JOIN_SIZE) join_size = value[19:0];
      else min_members = value[15:0];
    endfunction

    // Report strand s's open cluster if it is big enough
    function void close_cluster(int s);
      cluster_t       c;
      longint unsigned q;
      if (!has_prev[s] || members[s] == 0 || members[s] < min_members) return;
      q = longint'(score_sum[s]) / (longint'(members[s]) * SCORE_SCALE);
      if (q > MEAN_MAX) q = MEAN_MAX;
      c.minus       = (s == 1) ? STRAND_MINUS : STRAND_PLUS;
      c.chrom       = prev_chrom[s];
      c.first_start = first_start[s];
      c.last_end    = last_end[s];
      c.members     = members[s];
      c.mean        = q[9:0];
      c.last        = 1'b0;
      batch.push_back(c);
    endfunction

    function void note_request(site_req_t r);
      int s;
      batch.delete();
      if (r.action == ACT_FLUSH) begin
        close_cluster(0);
        close_cluster(1);
        clear_strand(0);
        clear_strand(1);
      end else begin
        s = (r.minus == STRAND_MINUS) ? 1 : 0;
        // Close on chromosome change or a start step beyond join_size (wraps)
        if (has_prev[s] && (r.chrom != prev_chrom[s] ||
            (r.site_start - prev_start[s]) > {12'd0, join_size})) begin
          close_cluster(s);
          members[s]   = '0;
          score_sum[s] = '0;
        end
        if (members[s] == 0) first_start[s] = r.site_start;
        // Saturated count drops further scores
        if (members[s] < COUNT_MAX) begin
          members[s]   = members[s] + 1;
          score_sum[s] = score_sum[s] + r.score;
        end
        last_end[s]   = r.site_end;
        prev_start[s] = r.site_start;
        prev_chrom[s] = r.chrom;
        has_prev[s]   = 1'b1;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(cluster_t got);
      cluster_t exp_c;
      if (expected_q.size() == 0) begin
        $error("unexpected cluster report: chrom %0d start %0d count %0d",
               got.chrom, got.first_start, got.members);
        errors++;
        return;
      end
      exp_c = expected_q.pop_front();
      compare_field("out_minus", exp_c.minus, got.minus);
      compare_field("out_chrom", exp_c.chrom, got.chrom);
      compare_field("cluster_start", exp_c.first_start, got.first_start);
      compare_field("cluster_end", exp_c.last_end, got.last_end);
      compare_field("member_count", exp_c.members, got.members);
      compare_field("mean_score", exp_c.mean, got.mean);
      compare_field("last_result", exp_c.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  cluster_scoreboard cluster_sb;
  int                send_idle_pct;
  int                recv_stall_pct;
  bit [7:0]          walk_chrom;
  bit [31:0]         walk_pos;
  int                quiet_cycles;

  stranded_distance_clusterer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive result-side backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Capture accepted cluster reports
  initial begin
    cluster_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.chrom       = out_tdata[7:0];
        got.first_start = out_tdata[39:8];
        got.last_end    = out_tdata[71:40];
        got.members     = out_tdata[87:72];
        got.mean        = out_tdata[97:88];
        got.minus       = out_tuser[0];
        got.last        = out_tlast;
        cluster_sb.check_result(got);
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one request, with random idle cycles ahead of it
  task automatic send_request(site_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, r.score, r.site_end, r.site_start, r.chrom};
    in_tuser  = {r.minus, r.action};
    do @(posedge clk); while (!in_tready);
    cluster_sb.note_request(r);
  endtask

  task automatic send_site(bit [7:0] chrom, bit [31:0] s_start, bit [31:0] s_end,
                           bit [19:0] score, bit minus);
    site_req_t r;
    r.action     = ACT_SITE;
    r.chrom      = chrom;
    r.site_start = s_start;
    r.site_end   = s_end;
    r.score      = score;
    r.minus      = minus;
    send_request(r);
  endtask

  // Flush with random payload, which the block must ignore
  task automatic send_flush();
    site_req_t r;
    r.action     = ACT_FLUSH;
    r.chrom      = $urandom;
    r.site_start = $urandom;
    r.site_end   = $urandom;
    r.score      = $urandom;
    r.minus      = $urandom_range(0, 1);
    send_request(r);
  endtask

  // Wait for every expected report, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (cluster_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(bit idx, bit [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cluster_sb.set_config(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_pace(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Mostly sorted walks along the genome, with flushes, jumps back and noise
  task automatic random_burst(int count);
    int        pick;
    bit [31:0] step;
    bit [19:0] score;
    site_req_t r;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_flush();
      end else if (pick < 16) begin
        r.action     = ACT_SITE;
        r.chrom      = $urandom;
        r.site_start = $urandom;
        r.site_end   = $urandom;
        r.score      = $urandom;
        r.minus      = $urandom_range(0, 1);
        send_request(r);
      end else begin
        if (pick < 20) begin
          walk_chrom = walk_chrom + 1;
          walk_pos   = $urandom_range(0, 1000);
        end else if (pick < 23) begin
          walk_pos = walk_pos - $urandom_range(1, 5000);
        end else begin
          if ($urandom_range(0, 3) == 0)
            step = cluster_sb.join_size + $urandom_range(1, 20);
          else
            step = $urandom_range(0, cluster_sb.join_size);
          walk_pos = walk_pos + step;
        end
        if ($urandom_range(0, 19) == 0) score = $urandom;
        else score = $urandom_range(0, 1000000);
        send_site(walk_chrom, walk_pos, walk_pos + $urandom_range(0, 3000), score,
                  $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    cluster_sb     = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    walk_chrom     = 8'd0;
    walk_pos       = 32'd0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b0 | 1'b1;

    // Reset settings: join at exactly join_size, wrapped step, backwards start
    send_site(8'd0, 32'd0, 32'd0, 20'd0, STRAND_PLUS);
    send_site(8'd0, 32'd100, 32'd150, 20'd1000000, STRAND_PLUS);
    send_site(8'd0, 32'd201, 32'd250, 20'd500000, STRAND_PLUS);
    send_site(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, STRAND_MINUS);
    send_site(8'd255, 32'd0, 32'd10, 20'hFFFFF, STRAND_MINUS);
    send_site(8'd255, 32'hFFFF_FF00, 32'd5, 20'd0, STRAND_MINUS);
    send_site(8'd1, 32'd260, 32'd300, 20'd1000000, STRAND_PLUS);
    send_flush();
    send_flush();
    send_site(8'd7, 32'd5, 32'd6, 20'd123456, STRAND_MINUS);
    send_flush();
    drain();

    // Widest join, small clusters held back
    cfg_write(REG_JOIN_SIZE, 32'hFFFFF);
    cfg_write(REG_MIN_CLUSTER, 32'd3);
    send_site(8'd2, 32'd0, 32'd1, 20'd10, STRAND_PLUS);
    send_site(8'd2, 32'hFFFFF, 32'd2, 20'd20, STRAND_PLUS);
    send_site(8'd2, 32'h1FFFFF, 32'd3, 20'd30, STRAND_PLUS);
    send_site(8'd2, 32'h1FFFFF, 32'd4, 20'd999999, STRAND_PLUS);
    send_site(8'd2, 32'h1FFFFF, 32'd5, 20'd1, STRAND_PLUS);
    send_site(8'd3, 32'd10, 32'd11, 20'd77, STRAND_MINUS);
    send_flush();
    drain();

    // Zero join and zero minimum: every closed cluster reports
    cfg_write(REG_JOIN_SIZE, 32'd0);
    cfg_write(REG_MIN_CLUSTER, 32'd0);
    send_site(8'd4, 32'd50, 32'd60, 20'd400000, STRAND_PLUS);
    send_site(8'd4, 32'd50, 32'd70, 20'd400001, STRAND_PLUS);
    send_site(8'd4, 32'd51, 32'd80, 20'd3, STRAND_PLUS);
    send_flush();
    drain();

    // Hold back every cluster under the largest minimum
    cfg_write(REG_MIN_CLUSTER, 32'hFFFF);
    for (int i = 0; i < 5; i++)
      send_site(8'd9, 32'd1000, $urandom, $urandom_range(0, 1000000), STRAND_PLUS);
    for (int i = 0; i < 3; i++)
      send_site(8'd9, 32'd1000, 32'd2000, 20'd500, STRAND_MINUS);
    send_flush();
    drain();

    // Random phases, each under its own settings and pacing
    set_pace(0, 0);
    cfg_write(REG_JOIN_SIZE, 32'd100);
    cfg_write(REG_MIN_CLUSTER, 32'd1);
    random_burst(110);
    drain();

    set_pace(77, 0);
    cfg_write(REG_JOIN_SIZE, 32'd5000);
    cfg_write(REG_MIN_CLUSTER, 32'd2);
    random_burst(110);
    drain();

    set_pace(0, 77);
    cfg_write(REG_JOIN_SIZE, 32'hFFFFF);
    cfg_write(REG_MIN_CLUSTER, 32'd1);
    random_burst(110);
    drain();

    set_pace(33, 33);
    cfg_write(REG_JOIN_SIZE, 32'd37);
    cfg_write(REG_MIN_CLUSTER, 32'd4);
    random_burst(110);
    send_flush();
    drain();

    if (cluster_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
